[rtl/core/lsbm_pkg.sv]
// ----------------------------------------------------------------------------
// lsbm_pkg
// Shared types, constants and helper functions of the scan box masking unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lsbm_pkg;

   localparam int MAX_BOXES_DEF = 16;
   localparam int BEAMS_DEF     = 360;

   localparam int COORD_W  = 24;
   localparam int RANGE_W  = 24;
   localparam int TRIG_W   = 16;
   localparam int IDX_W    = 9;
   localparam int OPND_W   = 28;
   localparam int PROD_W   = 2 * OPND_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam int CORD_W   = 34;
   localparam int ANGLE_W  = 33;
   localparam int PHASE_W  = 32;
   localparam int CORDIC_STEPS = 16;
   localparam logic signed [CORD_W-1:0] CORDIC_X0 = 34'sd652032874;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_COS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_SIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_X = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_Y = 2'd3;

   localparam logic OP_READING = 1'b0;
   localparam logic OP_ADD_BOX = 1'b1;

   localparam int TAG_W = 4;
   localparam logic [TAG_W-1:0] TAG_NONE = 4'd0;
   localparam logic [TAG_W-1:0] TAG_X    = 4'd1;
   localparam logic [TAG_W-1:0] TAG_Y    = 4'd2;
   localparam logic [TAG_W-1:0] TAG_MX   = 4'd3;
   localparam logic [TAG_W-1:0] TAG_MY   = 4'd4;
   localparam logic [TAG_W-1:0] TAG_D1   = 4'd5;
   localparam logic [TAG_W-1:0] TAG_D2   = 4'd6;
   localparam logic [TAG_W-1:0] TAG_D3   = 4'd7;
   localparam logic [TAG_W-1:0] TAG_D4   = 4'd8;

   typedef struct packed {
      logic                       op;
      logic [IDX_W-1:0]           beam_index;
      logic [RANGE_W-1:0]         range_in;
      logic                       range_valid;
      logic signed [COORD_W-1:0]  corner_a_x;
      logic signed [COORD_W-1:0]  corner_a_y;
      logic signed [COORD_W-1:0]  corner_b_x;
      logic signed [COORD_W-1:0]  corner_b_y;
      logic signed [COORD_W-1:0]  corner_c_x;
      logic signed [COORD_W-1:0]  corner_c_y;
   } req_type;

   typedef struct packed {
      logic [RANGE_W-1:0] range_out;
      logic               blanked;
      logic               inside_box;
      logic [4:0]         stored_boxes;
      logic               insert_dropped;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
   } box_type;

   localparam int BOX_W = $bits(box_type);

   typedef struct packed {
      logic                      valid;
      logic                      clear;
      logic                      negate;
      logic [TAG_W-1:0]          tag;
      logic signed [OPND_W-1:0]  a;
      logic signed [OPND_W-1:0]  b;
   } mac_op_type;

   function automatic logic signed [ANGLE_W-1:0] atan_turn(input logic [3:0] i);
      logic signed [ANGLE_W-1:0] v;
      unique case (i)
         4'd0:  v = 33'sd536870912;
         4'd1:  v = 33'sd316933406;
         4'd2:  v = 33'sd167458907;
         4'd3:  v = 33'sd85004756;
         4'd4:  v = 33'sd42667331;
         4'd5:  v = 33'sd21354465;
         4'd6:  v = 33'sd10679841;
         4'd7:  v = 33'sd5340245;
         4'd8:  v = 33'sd2670163;
         4'd9:  v = 33'sd1335087;
         4'd10: v = 33'sd667544;
         4'd11: v = 33'sd333772;
         4'd12: v = 33'sd166886;
         4'd13: v = 33'sd83443;
         4'd14: v = 33'sd41722;
         default: v = 33'sd20861;
      endcase
      return v;
   endfunction

   function automatic logic signed [TRIG_W-1:0] clamp16(input logic signed [CORD_W-1:0] v);
      logic signed [TRIG_W-1:0] r;
      if (v > 34'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -34'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[TRIG_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [TRIG_W-1:0] neg_sat16(input logic signed [TRIG_W-1:0] v);
      logic signed [TRIG_W:0] n;
      n = -{v[TRIG_W-1], v};
      return (n > 17'sd32767) ? 16'sh7fff : n[TRIG_W-1:0];
   endfunction

   function automatic logic signed [OPND_W-1:0] round15(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] t;
      t = (v + ACC_W'(16384)) >>> 15;
      return t[OPND_W-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/core/lsbm_ram.sv]
// ----------------------------------------------------------------------------
// lsbm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[rtl/core/lsbm_trig.sv]
// ----------------------------------------------------------------------------
// lsbm_trig
// Beam angle unit: reciprocal-multiply phase step followed by a shift-add CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbm_trig
   import lsbm_pkg::*;
#(
   parameter int BEAMS = BEAMS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [IDX_W-1:0]         beam_index,
   output logic                          done,
   output logic signed [TRIG_W-1:0]      cos_out,
   output logic signed [TRIG_W-1:0]      sin_out
);

   localparam int FRAC_W = 21;
   localparam int MAG_W  = 23;
   localparam int LOG_B  = $clog2(BEAMS);
   localparam int SHIFT  = FRAC_W + LOG_B;
   localparam longint unsigned TURN = 64'd1 << PHASE_W;
   localparam logic [PHASE_W-1:0] STEP_INT = PHASE_W'(TURN / 64'(BEAMS));
   localparam logic [FRAC_W-1:0]  STEP_REM = FRAC_W'(TURN % 64'(BEAMS));
   localparam logic [MAG_W-1:0]   MAGIC    =
      MAG_W'(((64'd1 << SHIFT) + 64'(BEAMS) - 64'd1) / 64'(BEAMS));
   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_DIV  = 2'd1;
   localparam logic [1:0] T_ROT  = 2'd2;
   localparam logic [1:0] T_FIN  = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic [5:0]                 cnt_ff, cnt_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [PHASE_W-1:0]         base_ff, base_in;
   logic [FRAC_W-1:0]          frac_ff, frac_in;
   logic [PHASE_W-1:0]         quo_ff, quo_in;
   logic signed [CORD_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [ANGLE_W-1:0]  z_ff, z_in;
   logic signed [TRIG_W-1:0]   c_ff, c_in, s_ff, s_in;
   logic                       done_ff, done_in;

   logic [IDX_W+PHASE_W-1:0]   base_prod;
   logic [FRAC_W+MAG_W-1:0]    frac_prod;
   logic signed [CORD_W-1:0]   dx, dy, xr, yr;
   logic signed [TRIG_W-1:0]   cq, sq;

   always_comb begin
      base_prod = (IDX_W+PHASE_W)'(idx_ff) * (IDX_W+PHASE_W)'(STEP_INT);
      frac_prod = (FRAC_W+MAG_W)'(frac_ff) * (FRAC_W+MAG_W)'(MAGIC);
      dx        = y_ff >>> cnt_ff[3:0];
      dy        = x_ff >>> cnt_ff[3:0];
      xr        = (x_ff + 34'sd16384) >>> 15;
      yr        = (y_ff + 34'sd16384) >>> 15;
      cq        = clamp16(xr);
      sq        = clamp16(yr);

      state_in = state_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      base_in  = base_ff;
      frac_in  = frac_ff;
      quo_in   = quo_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      c_in     = c_ff;
      s_in     = s_ff;
      done_in  = 1'b0;

      unique case (state_ff)
         T_IDLE: begin
            if (start) begin
               state_in = T_DIV;
               cnt_in   = '0;
               idx_in   = beam_index;
            end
         end
         T_DIV: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd0) begin
               base_in = base_prod[PHASE_W-1:0];
               frac_in = FRAC_W'(idx_ff) * STEP_REM;
            end else begin
               quo_in   = base_ff + PHASE_W'(frac_prod >> SHIFT);
               state_in = T_ROT;
               cnt_in   = '0;
               x_in     = CORDIC_X0;
               y_in     = '0;
               z_in     = $signed({3'b000, quo_in[PHASE_W-3:0]});
            end
         end
         T_ROT: begin
            if (!z_ff[ANGLE_W-1]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_turn(cnt_ff[3:0]);
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_turn(cnt_ff[3:0]);
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(CORDIC_STEPS - 1)) begin
               state_in = T_FIN;
            end
         end
         T_FIN: begin
            unique case (quo_ff[PHASE_W-1:PHASE_W-2])
               2'd0: begin c_in = cq;            s_in = sq;            end
               2'd1: begin c_in = neg_sat16(sq); s_in = cq;            end
               2'd2: begin c_in = neg_sat16(cq); s_in = neg_sat16(sq); end
               default: begin c_in = sq;         s_in = neg_sat16(cq); end
            endcase
            done_in  = 1'b1;
            state_in = T_IDLE;
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      base_ff <= base_in;
      frac_ff <= frac_in;
      quo_ff  <= quo_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      c_ff    <= c_in;
      s_ff    <= s_in;
   end

   assign done    = done_ff;
   assign cos_out = c_ff;
   assign sin_out = s_ff;

endmodule

`default_nettype wire

[rtl/core/lsbm_mac.sv]
// ----------------------------------------------------------------------------
// lsbm_mac
// Shared two-stage multiply-accumulate unit with a result tag.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbm_mac
   import lsbm_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire mac_op_type               mac_op,
   output logic signed [ACC_W-1:0]       acc,
   output logic [TAG_W-1:0]              acc_tag
);

   logic signed [PROD_W-1:0] prod_ff;
   logic                     p_valid_ff, p_clear_ff, p_neg_ff;
   logic [TAG_W-1:0]         p_tag_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, prod_ext;
   logic [TAG_W-1:0]         tag_ff;

   always_comb begin
      prod_ext = ACC_W'(prod_ff);
      acc_in   = p_clear_ff ? '0 : acc_ff;
      acc_in   = p_neg_ff ? (acc_in - prod_ext) : (acc_in + prod_ext);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         tag_ff     <= TAG_NONE;
      end else begin
         p_valid_ff <= mac_op.valid;
         tag_ff     <= p_valid_ff ? p_tag_ff : TAG_NONE;
      end
      prod_ff    <= mac_op.a * mac_op.b;
      p_clear_ff <= mac_op.clear;
      p_neg_ff   <= mac_op.negate;
      p_tag_ff   <= mac_op.tag;
      if (p_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign acc     = acc_ff;
   assign acc_tag = tag_ff;

endmodule

`default_nettype wire

[rtl/core/laser_scan_box_masking_unit.sv]
// ----------------------------------------------------------------------------
// laser_scan_box_masking_unit
// Masks laser range readings that fall inside rectangles held in a box table.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. An add-box
// transaction stores corners A, B and C in the next free table entry, or is
// flagged as dropped when the table is full. A valid reading is turned
// into a map point and tested against the stored boxes until the first hit.
// Each transaction gives one result on rsp_payload, marked by rsp_strobe for
// one cycle; the receiver cannot stall it.
// Add-box and invalid readings give their result in the cycle after
// acceptance and the next transaction may be taken in that cycle. A valid
// reading passes through the angle unit (the phase product, 16 CORDIC
// steps, the quadrant fold and an output register), then the point
// transform through the shared multiplier, then one box test per stored
// box until the first hit.
// The block takes no new transaction while busy.
// Configuration writes on the csr_ channel are always ready and take effect
// at once. Reset clears the box count and loads the identity transform.
// ----------------------------------------------------------------------------
`default_nettype none

module laser_scan_box_masking_unit
   import lsbm_pkg::*;
#(
   parameter int MAX_BOXES = MAX_BOXES_DEF,
   parameter int BEAMS     = BEAMS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire req_type                req_payload,
   output logic                        rsp_strobe,
   output rsp_type                     rsp_payload,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CW = $clog2(MAX_BOXES + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_TRIG = 4'd1;
   localparam logic [3:0] S_PT1  = 4'd2;
   localparam logic [3:0] S_PT2  = 4'd3;
   localparam logic [3:0] S_RD   = 4'd4;
   localparam logic [3:0] S_DIF  = 4'd5;
   localparam logic [3:0] S_BOX  = 4'd6;
   localparam logic [3:0] S_CMP  = 4'd7;

   logic [3:0]                state_ff, state_in;
   logic [3:0]                cnt_ff, cnt_in;
   logic [AW-1:0]             k_ff, k_in;
   logic [CW-1:0]             total_ff, total_in;
   logic signed [TRIG_W-1:0]  rot_cos_ff, rot_sin_ff;
   logic signed [COORD_W-1:0] shift_x_ff, shift_y_ff;
   logic [RANGE_W-1:0]        range_ff, range_in;
   logic signed [OPND_W-1:0]  px_ff, px_in, py_ff, py_in, mx_ff, mx_in, my_ff, my_in;
   logic signed [OPND_W-1:0]  abx_ff, aby_ff, bcx_ff, bcy_ff;
   logic signed [OPND_W-1:0]  amx_ff, amy_ff, bmx_ff, bmy_ff;
   logic signed [ACC_W-1:0]   d1_ff, d1_in, d2_ff, d2_in, d3_ff, d3_in, d4_ff, d4_in;
   logic                      strobe_ff, strobe_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      accept, trig_start, trig_done, wr_en, hit, last_box;
   logic signed [TRIG_W-1:0]  trig_cos, trig_sin;
   logic [8:0]                total_ext;
   box_type                   box_rd, box_wr;
   mac_op_type                mac_op;
   logic signed [ACC_W-1:0]   mac_acc;
   logic [TAG_W-1:0]          mac_tag;
   logic signed [OPND_W-1:0]  ax, ay, bx, by, cx, cy;
   logic signed [OPND_W-1:0]  range_op, cos_op, sin_op, rc_op, rs_op;

   assign accept     = start && !busy;
   assign trig_start = accept && (req_payload.op == OP_READING) && req_payload.range_valid;
   assign csr_ready  = 1'b1;

   assign box_wr.ax = req_payload.corner_a_x;
   assign box_wr.ay = req_payload.corner_a_y;
   assign box_wr.bx = req_payload.corner_b_x;
   assign box_wr.by = req_payload.corner_b_y;
   assign box_wr.cx = req_payload.corner_c_x;
   assign box_wr.cy = req_payload.corner_c_y;
   assign wr_en     = accept && (req_payload.op == OP_ADD_BOX) &&
                      ((CW+1)'(total_ff) < (CW+1)'(MAX_BOXES));

   lsbm_ram #(
      .WIDTH (BOX_W),
      .DEPTH (MAX_BOXES)
   ) u_box_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (total_ff[AW-1:0]),
      .wr_data (box_wr),
      .rd_addr (k_ff),
      .rd_data (box_rd)
   );

   lsbm_trig #(
      .BEAMS (BEAMS)
   ) u_trig (
      .clock      (clock),
      .reset      (reset),
      .start      (trig_start),
      .beam_index (req_payload.beam_index),
      .done       (trig_done),
      .cos_out    (trig_cos),
      .sin_out    (trig_sin)
   );

   lsbm_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .mac_op  (mac_op),
      .acc     (mac_acc),
      .acc_tag (mac_tag)
   );

   always_comb begin
      ax = {{(OPND_W-COORD_W){box_rd.ax[COORD_W-1]}}, box_rd.ax};
      ay = {{(OPND_W-COORD_W){box_rd.ay[COORD_W-1]}}, box_rd.ay};
      bx = {{(OPND_W-COORD_W){box_rd.bx[COORD_W-1]}}, box_rd.bx};
      by = {{(OPND_W-COORD_W){box_rd.by[COORD_W-1]}}, box_rd.by};
      cx = {{(OPND_W-COORD_W){box_rd.cx[COORD_W-1]}}, box_rd.cx};
      cy = {{(OPND_W-COORD_W){box_rd.cy[COORD_W-1]}}, box_rd.cy};
      range_op = $signed({{(OPND_W-RANGE_W){1'b0}}, range_ff});
      cos_op   = {{(OPND_W-TRIG_W){trig_cos[TRIG_W-1]}}, trig_cos};
      sin_op   = {{(OPND_W-TRIG_W){trig_sin[TRIG_W-1]}}, trig_sin};
      rc_op    = {{(OPND_W-TRIG_W){rot_cos_ff[TRIG_W-1]}}, rot_cos_ff};
      rs_op    = {{(OPND_W-TRIG_W){rot_sin_ff[TRIG_W-1]}}, rot_sin_ff};
   end

   always_comb begin
      mac_op = '0;
      unique case (state_ff)
         S_PT1: begin
            unique case (cnt_ff)
               4'd0: mac_op = '{1'b1, 1'b1, 1'b0, TAG_X, range_op, cos_op};
               4'd1: mac_op = '{1'b1, 1'b1, 1'b0, TAG_Y, range_op, sin_op};
               default: mac_op = '0;
            endcase
         end
         S_PT2: begin
            unique case (cnt_ff)
               4'd0: mac_op = '{1'b1, 1'b1, 1'b0, TAG_NONE, rc_op, px_ff};
               4'd1: mac_op = '{1'b1, 1'b0, 1'b1, TAG_MX, rs_op, py_ff};
               4'd2: mac_op = '{1'b1, 1'b1, 1'b0, TAG_NONE, rs_op, px_ff};
               4'd3: mac_op = '{1'b1, 1'b0, 1'b0, TAG_MY, rc_op, py_ff};
               default: mac_op = '0;
            endcase
         end
         S_BOX: begin
            unique case (cnt_ff)
               4'd0: mac_op = '{1'b1, 1'b1, 1'b0, TAG_NONE, abx_ff, amx_ff};
               4'd1: mac_op = '{1'b1, 1'b0, 1'b0, TAG_D1, aby_ff, amy_ff};
               4'd2: mac_op = '{1'b1, 1'b1, 1'b0, TAG_NONE, abx_ff, abx_ff};
               4'd3: mac_op = '{1'b1, 1'b0, 1'b0, TAG_D2, aby_ff, aby_ff};
               4'd4: mac_op = '{1'b1, 1'b1, 1'b0, TAG_NONE, bcx_ff, bmx_ff};
               4'd5: mac_op = '{1'b1, 1'b0, 1'b0, TAG_D3, bcy_ff, bmy_ff};
               4'd6: mac_op = '{1'b1, 1'b1, 1'b0, TAG_NONE, bcx_ff, bcx_ff};
               4'd7: mac_op = '{1'b1, 1'b0, 1'b0, TAG_D4, bcy_ff, bcy_ff};
               default: mac_op = '0;
            endcase
         end
         default: mac_op = '0;
      endcase
   end

   always_comb begin
      px_in = px_ff;
      py_in = py_ff;
      mx_in = mx_ff;
      my_in = my_ff;
      d1_in = d1_ff;
      d2_in = d2_ff;
      d3_in = d3_ff;
      d4_in = d4_ff;
      unique case (mac_tag)
         TAG_X:  px_in = round15(mac_acc);
         TAG_Y:  py_in = round15(mac_acc);
         TAG_MX: mx_in = round15(mac_acc) +
                         {{(OPND_W-COORD_W){shift_x_ff[COORD_W-1]}}, shift_x_ff};
         TAG_MY: my_in = round15(mac_acc) +
                         {{(OPND_W-COORD_W){shift_y_ff[COORD_W-1]}}, shift_y_ff};
         TAG_D1: d1_in = mac_acc;
         TAG_D2: d2_in = mac_acc;
         TAG_D3: d3_in = mac_acc;
         TAG_D4: d4_in = mac_acc;
         default: ;
      endcase
   end

   always_comb begin
      hit       = !d1_ff[ACC_W-1] && (d1_ff <= d2_ff) && !d3_ff[ACC_W-1] && (d3_ff <= d4_ff);
      last_box  = ((CW+1)'(k_ff) + (CW+1)'(1)) == (CW+1)'(total_ff);
      total_ext = 9'(total_ff);

      state_in  = state_ff;
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      total_in  = total_ff;
      range_in  = range_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               range_in = req_payload.range_in;
               rsp_in   = '0;
               if (req_payload.op == OP_ADD_BOX) begin
                  if (wr_en) begin
                     total_in = total_ff + CW'(1);
                  end else begin
                     rsp_in.insert_dropped = 1'b1;
                  end
                  rsp_in.stored_boxes = 5'(9'(total_in));
                  strobe_in = 1'b1;
               end else if (!req_payload.range_valid) begin
                  rsp_in.blanked      = 1'b1;
                  rsp_in.stored_boxes = total_ext[4:0];
                  strobe_in = 1'b1;
               end else begin
                  state_in = S_TRIG;
               end
            end
         end
         S_TRIG: begin
            if (trig_done) begin
               state_in = S_PT1;
               cnt_in   = '0;
            end
         end
         S_PT1: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd3) begin
               state_in = S_PT2;
               cnt_in   = '0;
            end
         end
         S_PT2: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd5) begin
               cnt_in = '0;
               k_in   = '0;
               if (total_ff == '0) begin
                  rsp_in.range_out      = range_ff;
                  rsp_in.blanked        = 1'b0;
                  rsp_in.inside_box     = 1'b0;
                  rsp_in.stored_boxes   = total_ext[4:0];
                  rsp_in.insert_dropped = 1'b0;
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD:  state_in = S_DIF;
         S_DIF: begin
            state_in = S_BOX;
            cnt_in   = '0;
         end
         S_BOX: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd9) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (hit || last_box) begin
               rsp_in.range_out      = hit ? '0 : range_ff;
               rsp_in.blanked        = hit;
               rsp_in.inside_box     = hit;
               rsp_in.stored_boxes   = total_ext[4:0];
               rsp_in.insert_dropped = 1'b0;
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               k_in     = k_ff + AW'(1);
               state_in = S_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         total_ff   <= '0;
         strobe_ff  <= 1'b0;
         rot_cos_ff <= 16'sh7fff;
         rot_sin_ff <= '0;
         shift_x_ff <= '0;
         shift_y_ff <= '0;
      end else begin
         state_ff  <= state_in;
         total_ff  <= total_in;
         strobe_ff <= strobe_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ROT_COS: rot_cos_ff <= csr_data[TRIG_W-1:0];
               CSR_ROT_SIN: rot_sin_ff <= csr_data[TRIG_W-1:0];
               CSR_SHIFT_X: shift_x_ff <= csr_data;
               default:     shift_y_ff <= csr_data;
            endcase
         end
      end
      cnt_ff   <= cnt_in;
      k_ff     <= k_in;
      range_ff <= range_in;
      rsp_ff   <= rsp_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      d1_ff    <= d1_in;
      d2_ff    <= d2_in;
      d3_ff    <= d3_in;
      d4_ff    <= d4_in;
      if (state_ff == S_DIF) begin
         abx_ff <= bx - ax;
         aby_ff <= by - ay;
         bcx_ff <= cx - bx;
         bcy_ff <= cy - by;
         amx_ff <= mx_ff - ax;
         amy_ff <= my_ff - ay;
         bmx_ff <= mx_ff - bx;
         bmy_ff <= my_ff - by;
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobed while still busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (CW+1)'(total_ff) <= (CW+1)'(MAX_BOXES))
      else $error("box count beyond table depth");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_strobe))
      else $error("accepted transaction neither busy nor answered");

   a_inside_blanked: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.inside_box) |-> rsp_payload.blanked)
      else $error("point inside a box not blanked");

endmodule

`default_nettype wire
